>>> hdl/slp_pkg.sv
`default_nettype none

package slp_pkg;

    localparam int WIDTH    = 256;
    localparam int HEIGHT   = 256;
    localparam int FRAC     = 17;
    localparam int NUM_ELL  = 10;
    localparam int PIX_W    = 8;

    // pixel index minus half the grid, then scaled up to q.17
    localparam int CTR_W    = PIX_W + 1;
    localparam int X_SHIFT  = FRAC + 1 - $clog2(WIDTH);
    localparam int Y_SHIFT  = FRAC + 1 - $clog2(HEIGHT);

    localparam int U_W      = 19;
    localparam int PROD_W   = 2 * U_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int D_W      = 20;
    localparam int SQ_W     = 2 * D_W;
    localparam int SQ_HALF  = SQ_W / 2;
    localparam int AX_W     = 17;
    localparam int K_W      = 2 * AX_W;
    localparam int K_HALF   = K_W / 2;
    localparam int PP_W     = SQ_HALF + K_HALF;
    localparam int TERM_W   = SQ_W + K_W;
    localparam int LHS_W    = TERM_W + 1;
    localparam int TENTHS_W = 6;

    typedef enum logic [1:0] {
        ROT_NONE,
        ROT_POS,
        ROT_NEG
    } rot_t;

    typedef struct packed {
        logic signed [TENTHS_W-1:0] tenths;
        logic signed [17:0]         x0;
        logic signed [17:0]         y0;
        logic [AX_W-1:0]            a;
        logic [AX_W-1:0]            b;
        rot_t                       rot;
    } ellipse_t;

    localparam ellipse_t ELL_TAB [NUM_ELL] = '{
        '{ 6'sd10,        18'sd0,       18'sd0, 17'd90440, 17'd120586, ROT_NONE},
        '{-6'sd8,         18'sd0,   -18'sd2412, 17'd86822, 17'd114557, ROT_NONE},
        '{-6'sd2,     18'sd28836,       18'sd0, 17'd14418,  17'd40632, ROT_NEG },
        '{-6'sd2,    -18'sd28836,       18'sd0, 17'd20972,  17'd53740, ROT_POS },
        '{ 6'sd1,         18'sd0,   18'sd45875, 17'd27525,  17'd32768, ROT_NONE},
        '{ 6'sd1,         18'sd0,   18'sd13107,  17'd6029,   17'd6029, ROT_NONE},
        '{ 6'sd1,         18'sd0,  -18'sd13107,  17'd6029,   17'd6029, ROT_NONE},
        '{ 6'sd1,    -18'sd10486,  -18'sd79299,  17'd6029,   17'd3015, ROT_NONE},
        '{ 6'sd1,         18'sd0,  -18'sd79299,  17'd3015,   17'd3015, ROT_NONE},
        '{ 6'sd1,      18'sd7864,  -18'sd79299,  17'd3015,   17'd6029, ROT_NONE}
    };

    localparam logic signed [U_W-1:0] ONE_Q   = 19'sd131072;
    localparam logic signed [U_W-1:0] COS18_Q = 19'sd124657;
    localparam logic signed [U_W-1:0] SIN18_Q = 19'sd40503;

    function automatic logic signed [U_W-1:0] cos_of(input rot_t rot);
        logic signed [U_W-1:0] c;
        unique case (rot)
            ROT_POS, ROT_NEG: c = COS18_Q;
            default:          c = ONE_Q;
        endcase
        return c;
    endfunction

    function automatic logic signed [U_W-1:0] sin_of(input rot_t rot);
        logic signed [U_W-1:0] s;
        unique case (rot)
            ROT_POS: s = SIN18_Q;
            ROT_NEG: s = -SIN18_Q;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/shepp_logan_phantom_pixel.sv
// shepp-logan phantom pixel generator
//
// input request on px_valid / px_ready carries col and row of one pixel of
// the 256x256 grid. output request on dn_valid / dn_ready carries
// density_tenths, the summed intensity of all ellipses covering that pixel,
// in signed tenths (-12..16). one result per input, in input order.
//
// throughput: one pixel per clock while dn_ready does not hold the pipe.
// the eight stages are: offset from each ellipse center, rotation products,
// rotate and round, squares, partial products against the constant squared
// axes, term sums, the final compare, and the intensity sum into the output
// register.
//
// each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so a stall on dn_ready backs up one stage at a time and
// empty slots still take new pixels. nothing is lost or repeated.
// reset clears all valid bits; the pipe is empty and ready right after.
`default_nettype none

module shepp_logan_phantom_pixel (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                px_valid,
    output logic                px_ready,
    input  logic [7:0]          col,
    input  logic [7:0]          row,
    output logic                dn_valid,
    input  logic                dn_ready,
    output logic signed [5:0]   density_tenths
);

    localparam int NS = 8;
    localparam int NE = slp_pkg::NUM_ELL;
    localparam int U_W = slp_pkg::U_W;
    localparam int PROD_W = slp_pkg::PROD_W;
    localparam int SUM_W = slp_pkg::SUM_W;
    localparam int D_W = slp_pkg::D_W;
    localparam int SQ_W = slp_pkg::SQ_W;
    localparam int SQ_HALF = slp_pkg::SQ_HALF;
    localparam int K_W = slp_pkg::K_W;
    localparam int K_HALF = slp_pkg::K_HALF;
    localparam int PP_W = slp_pkg::PP_W;
    localparam int TERM_W = slp_pkg::TERM_W;
    localparam int LHS_W = slp_pkg::LHS_W;
    localparam int TENTHS_W = slp_pkg::TENTHS_W;
    localparam int CTR_W = slp_pkg::CTR_W;

    // partial product slots: square half times constant half
    localparam int PP_LL = 0;
    localparam int PP_LH = 1;
    localparam int PP_HL = 2;
    localparam int PP_HH = 3;

    localparam logic signed [SUM_W-1:0] RND = SUM_W'(1) <<< (slp_pkg::FRAC - 1);

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] rdy;
    logic [NS-1:0] v_in;
    logic [NS-1:0] ld;

    always_comb
    begin
        rdy[NS-1] = !v_reg[NS-1] || dn_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign v_in = {v_reg[NS-2:0], px_valid};
    assign ld = rdy & v_in;
    assign px_ready = rdy[0];
    assign dn_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (rdy & v_in) | (~rdy & v_reg);
        end
    end

    // squared semi-axes, constant per ellipse
    logic [K_W-1:0] a2_c [NE];
    logic [K_W-1:0] b2_c [NE];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            a2_c[i] = K_W'(slp_pkg::ELL_TAB[i].a) * K_W'(slp_pkg::ELL_TAB[i].a);
            b2_c[i] = K_W'(slp_pkg::ELL_TAB[i].b) * K_W'(slp_pkg::ELL_TAB[i].b);
        end
    end

    // stage 0: offsets from ellipse centers
    logic signed [CTR_W-1:0] col_c;
    logic signed [CTR_W-1:0] row_c;
    logic signed [U_W-1:0]   nx;
    logic signed [U_W-1:0]   ny;
    logic signed [U_W-1:0]   ux_next [NE];
    logic signed [U_W-1:0]   uy_next [NE];
    logic signed [U_W-1:0]   ux_reg [NE];
    logic signed [U_W-1:0]   uy_reg [NE];

    always_comb
    begin
        col_c = $signed({1'b0, col}) - $signed(CTR_W'(slp_pkg::WIDTH / 2));
        row_c = $signed({1'b0, row}) - $signed(CTR_W'(slp_pkg::HEIGHT / 2));
        nx = U_W'(col_c) <<< slp_pkg::X_SHIFT;
        ny = U_W'(row_c) <<< slp_pkg::Y_SHIFT;
        for (int i = 0; i < NE; i++)
        begin
            ux_next[i] = nx - U_W'(slp_pkg::ELL_TAB[i].x0);
            uy_next[i] = ny - U_W'(slp_pkg::ELL_TAB[i].y0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
    end

    // stage 1: rotation products
    logic signed [PROD_W-1:0] pcx_next [NE];
    logic signed [PROD_W-1:0] psy_next [NE];
    logic signed [PROD_W-1:0] pcy_next [NE];
    logic signed [PROD_W-1:0] psx_next [NE];
    logic signed [PROD_W-1:0] pcx_reg [NE];
    logic signed [PROD_W-1:0] psy_reg [NE];
    logic signed [PROD_W-1:0] pcy_reg [NE];
    logic signed [PROD_W-1:0] psx_reg [NE];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            pcx_next[i] = PROD_W'(slp_pkg::cos_of(slp_pkg::ELL_TAB[i].rot)) * PROD_W'(ux_reg[i]);
            psy_next[i] = PROD_W'(slp_pkg::sin_of(slp_pkg::ELL_TAB[i].rot)) * PROD_W'(uy_reg[i]);
            pcy_next[i] = PROD_W'(slp_pkg::cos_of(slp_pkg::ELL_TAB[i].rot)) * PROD_W'(uy_reg[i]);
            psx_next[i] = PROD_W'(slp_pkg::sin_of(slp_pkg::ELL_TAB[i].rot)) * PROD_W'(ux_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            pcx_reg <= pcx_next;
            psy_reg <= psy_next;
            pcy_reg <= pcy_next;
            psx_reg <= psx_next;
        end
    end

    // stage 2: rotate and round to q.17, ties toward plus infinity
    logic signed [SUM_W-1:0] sx [NE];
    logic signed [SUM_W-1:0] sy [NE];
    logic signed [D_W-1:0]   dx_next [NE];
    logic signed [D_W-1:0]   dy_next [NE];
    logic signed [D_W-1:0]   dx_reg [NE];
    logic signed [D_W-1:0]   dy_reg [NE];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            sx[i] = SUM_W'(pcx_reg[i]) + SUM_W'(psy_reg[i]) + RND;
            sy[i] = SUM_W'(pcy_reg[i]) - SUM_W'(psx_reg[i]) + RND;
            dx_next[i] = D_W'(sx[i] >>> slp_pkg::FRAC);
            dy_next[i] = D_W'(sy[i] >>> slp_pkg::FRAC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // stage 3: squares
    logic signed [SQ_W-1:0] sqx_s [NE];
    logic signed [SQ_W-1:0] sqy_s [NE];
    logic [SQ_W-1:0]        sqx_reg [NE];
    logic [SQ_W-1:0]        sqy_reg [NE];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            sqx_s[i] = SQ_W'(dx_reg[i]) * SQ_W'(dx_reg[i]);
            sqy_s[i] = SQ_W'(dy_reg[i]) * SQ_W'(dy_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            for (int i = 0; i < NE; i++)
            begin
                sqx_reg[i] <= $unsigned(sqx_s[i]);
                sqy_reg[i] <= $unsigned(sqy_s[i]);
            end
        end
    end

    // stage 4: partial products, dx^2 * b^2 and dy^2 * a^2
    logic [PP_W-1:0] ppx_next [NE][4];
    logic [PP_W-1:0] ppy_next [NE][4];
    logic [PP_W-1:0] ppx_reg [NE][4];
    logic [PP_W-1:0] ppy_reg [NE][4];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            ppx_next[i][PP_LL] = PP_W'(sqx_reg[i][SQ_HALF-1:0]) * PP_W'(b2_c[i][K_HALF-1:0]);
            ppx_next[i][PP_LH] = PP_W'(sqx_reg[i][SQ_HALF-1:0]) * PP_W'(b2_c[i][K_W-1:K_HALF]);
            ppx_next[i][PP_HL] = PP_W'(sqx_reg[i][SQ_W-1:SQ_HALF]) * PP_W'(b2_c[i][K_HALF-1:0]);
            ppx_next[i][PP_HH] = PP_W'(sqx_reg[i][SQ_W-1:SQ_HALF]) * PP_W'(b2_c[i][K_W-1:K_HALF]);
            ppy_next[i][PP_LL] = PP_W'(sqy_reg[i][SQ_HALF-1:0]) * PP_W'(a2_c[i][K_HALF-1:0]);
            ppy_next[i][PP_LH] = PP_W'(sqy_reg[i][SQ_HALF-1:0]) * PP_W'(a2_c[i][K_W-1:K_HALF]);
            ppy_next[i][PP_HL] = PP_W'(sqy_reg[i][SQ_W-1:SQ_HALF]) * PP_W'(a2_c[i][K_HALF-1:0]);
            ppy_next[i][PP_HH] = PP_W'(sqy_reg[i][SQ_W-1:SQ_HALF]) * PP_W'(a2_c[i][K_W-1:K_HALF]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            ppx_reg <= ppx_next;
            ppy_reg <= ppy_next;
        end
    end

    // stage 5: recombine partial products
    logic [TERM_W-1:0] tx_next [NE];
    logic [TERM_W-1:0] ty_next [NE];
    logic [TERM_W-1:0] tx_reg [NE];
    logic [TERM_W-1:0] ty_reg [NE];

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            tx_next[i] = (TERM_W'(ppx_reg[i][PP_HH]) << (SQ_HALF + K_HALF))
                       + (TERM_W'(ppx_reg[i][PP_HL]) << SQ_HALF)
                       + (TERM_W'(ppx_reg[i][PP_LH]) << K_HALF)
                       + TERM_W'(ppx_reg[i][PP_LL]);
            ty_next[i] = (TERM_W'(ppy_reg[i][PP_HH]) << (SQ_HALF + K_HALF))
                       + (TERM_W'(ppy_reg[i][PP_HL]) << SQ_HALF)
                       + (TERM_W'(ppy_reg[i][PP_LH]) << K_HALF)
                       + TERM_W'(ppy_reg[i][PP_LL]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            tx_reg <= tx_next;
            ty_reg <= ty_next;
        end
    end

    // stage 6: containment test against a^2 * b^2
    logic [NE-1:0] ins_next;
    logic [NE-1:0] ins_reg;

    always_comb
    begin
        for (int i = 0; i < NE; i++)
        begin
            ins_next[i] = (LHS_W'(tx_reg[i]) + LHS_W'(ty_reg[i]))
                       <= (LHS_W'(a2_c[i]) * LHS_W'(b2_c[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[6])
        begin
            ins_reg <= ins_next;
        end
    end

    // stage 7: intensity sum into output register
    logic signed [TENTHS_W-1:0] dens_next;
    logic signed [TENTHS_W-1:0] dens_reg;

    always_comb
    begin
        dens_next = '0;
        for (int i = 0; i < NE; i++)
        begin
            if (ins_reg[i])
            begin
                dens_next = dens_next + slp_pkg::ELL_TAB[i].tenths;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            dens_reg <= dens_next;
        end
    end

    assign density_tenths = dens_reg;

    // with the last stage empty every stage can move
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> px_ready)
        else $error("input blocked with an empty output stage");

    // occupancy follows accepted and delivered requests
    a_fill_up: assert property (@(posedge clk) disable iff (!rst_n)
        (px_valid && px_ready && !(dn_valid && dn_ready))
        |=> ($countones(v_reg) == $past($countones(v_reg)) + 1))
        else $error("pipeline occupancy did not grow on accept");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!(px_valid && px_ready) && dn_valid && dn_ready)
        |=> ($countones(v_reg) + 1 == $past($countones(v_reg))))
        else $error("pipeline occupancy did not shrink on delivery");

    // a stalled compare stage keeps its result bits
    a_hold_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[6] && !rdy[6]) |=> (v_reg[6] && $stable(ins_reg)))
        else $error("stalled containment bits changed");

    a_density_range: assert property (@(posedge clk) disable iff (!rst_n)
        dn_valid |-> (density_tenths >= -6'sd12 && density_tenths <= 6'sd16))
        else $error("density out of range");

endmodule

`default_nettype wire

>>> tb/phantom_density_check.sv
`timescale 1ns / 100ps

module phantom_density_check (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              px_valid,
    input  logic              px_ready,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    input  logic              dn_valid,
    input  logic              dn_ready,
    input  logic signed [5:0] density_tenths,
    output int                errors,
    output int                in_flight
);

    localparam longint Q_ONE   = 131072;
    localparam longint Q_COS18 = 124657;
    localparam longint Q_SIN18 = 40503;
    localparam int     N_ELL   = 10;

    typedef enum {
        TILT_NONE,
        TILT_POS,
        TILT_NEG
    } tilt_e;

    logic signed [5:0] density_q [$];
    logic signed [5:0] want;
    int                err_cnt = 0;
    int                pend_cnt = 0;

    assign errors    = err_cnt;
    assign in_flight = pend_cnt;

    // (2p - size) / size in q.17, round to nearest, ties up
    function automatic longint q17_coord(input longint p, input longint size);
        longint num;
        longint den;
        longint q;
        num = (2 * p - size) * (Q_ONE * 2) + size;
        den = 2 * size;
        q   = num / den;
        if (num % den != 0 && num < 0)
            q--;
        return q;
    endfunction

    function automatic logic signed [5:0] phantom_density(input logic [7:0] c,
                                                          input logic [7:0] r);
        longint       nx, ny, x0, y0, ax, bx, cs, sn, ux, uy, dx, dy;
        int           tenths;
        int           total;
        tilt_e        tilt;
        logic [127:0] adx, ady, aa, bb, lhs, rhs;
        nx    = q17_coord(c, slp_pkg::WIDTH);
        ny    = q17_coord(r, slp_pkg::HEIGHT);
        total = 0;
        for (int k = 0; k < N_ELL; k++)
        begin
            case (k)
                0:
                begin
                    tenths = 10;  x0 = 0;      y0 = 0;
                    ax = 90440;   bx = 120586; tilt = TILT_NONE;
                end
                1:
                begin
                    tenths = -8;  x0 = 0;      y0 = -2412;
                    ax = 86822;   bx = 114557; tilt = TILT_NONE;
                end
                2:
                begin
                    tenths = -2;  x0 = 28836;  y0 = 0;
                    ax = 14418;   bx = 40632;  tilt = TILT_NEG;
                end
                3:
                begin
                    tenths = -2;  x0 = -28836; y0 = 0;
                    ax = 20972;   bx = 53740;  tilt = TILT_POS;
                end
                4:
                begin
                    tenths = 1;   x0 = 0;      y0 = 45875;
                    ax = 27525;   bx = 32768;  tilt = TILT_NONE;
                end
                5:
                begin
                    tenths = 1;   x0 = 0;      y0 = 13107;
                    ax = 6029;    bx = 6029;   tilt = TILT_NONE;
                end
                6:
                begin
                    tenths = 1;   x0 = 0;      y0 = -13107;
                    ax = 6029;    bx = 6029;   tilt = TILT_NONE;
                end
                7:
                begin
                    tenths = 1;   x0 = -10486; y0 = -79299;
                    ax = 6029;    bx = 3015;   tilt = TILT_NONE;
                end
                8:
                begin
                    tenths = 1;   x0 = 0;      y0 = -79299;
                    ax = 3015;    bx = 3015;   tilt = TILT_NONE;
                end
                default:
                begin
                    tenths = 1;   x0 = 7864;   y0 = -79299;
                    ax = 3015;    bx = 6029;   tilt = TILT_NONE;
                end
            endcase
            case (tilt)
                TILT_POS:
                begin
                    cs = Q_COS18;
                    sn = Q_SIN18;
                end
                TILT_NEG:
                begin
                    cs = Q_COS18;
                    sn = -Q_SIN18;
                end
                default:
                begin
                    cs = Q_ONE;
                    sn = 0;
                end
            endcase
            ux = nx - x0;
            uy = ny - y0;
            // q.34 back to q.17, ties toward plus infinity
            dx = (cs * ux + sn * uy + 65536) >>> 17;
            dy = (cs * uy - sn * ux + 65536) >>> 17;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            aa  = ax * ax;
            bb  = bx * bx;
            lhs = adx * adx * bb + ady * ady * aa;
            rhs = aa * bb;
            if (lhs <= rhs)
                total += tenths;
        end
        return total[5:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (px_valid && px_ready)
                density_q.push_back(phantom_density(col, row));
            if (dn_valid && dn_ready)
            begin
                if (density_q.size() == 0)
                begin
                    $error("density_tenths: expected none pending, actual %0d",
                           density_tenths);
                    err_cnt++;
                end
                else
                begin
                    want = density_q.pop_front();
                    if (density_tenths !== want)
                    begin
                        $error("density_tenths: expected %0d, actual %0d",
                               want, density_tenths);
                        err_cnt++;
                    end
                end
            end
            pend_cnt = density_q.size();
        end
    end

endmodule

>>> tb/tb_shepp_logan_phantom_pixel.sv
`timescale 1ns / 100ps

module tb_shepp_logan_phantom_pixel;

    localparam int LONG_HOLD  = 200;
    localparam int PHASE_LEN  = 220;
    localparam int TAIL_WAIT  = 20;

    logic              clk;
    logic              rst_n;
    logic              px_valid;
    logic              px_ready;
    logic [7:0]        col;
    logic [7:0]        row;
    logic              dn_valid;
    logic              dn_ready;
    logic signed [5:0] density_tenths;

    int                mismatches;
    int                in_flight;
    bit                quiet    = 1'b0;
    bit                hold_req = 1'b0;

    shepp_logan_phantom_pixel i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .px_valid       (px_valid),
        .px_ready       (px_ready),
        .col            (col),
        .row            (row),
        .dn_valid       (dn_valid),
        .dn_ready       (dn_ready),
        .density_tenths (density_tenths)
    );

    phantom_density_check i_density_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .px_valid       (px_valid),
        .px_ready       (px_ready),
        .col            (col),
        .row            (row),
        .dn_valid       (dn_valid),
        .dn_ready       (dn_ready),
        .density_tenths (density_tenths),
        .errors         (mismatches),
        .in_flight      (in_flight)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // called and returns at a falling edge
    task automatic send_pixel(input logic [7:0] c, input logic [7:0] r);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            px_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        px_valid <= 1'b1;
        col      <= c;
        row      <= r;
        @(posedge clk);
        while (!px_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input int n);
        logic [7:0] c;
        logic [7:0] r;
        for (int i = 0; i < n; i++)
        begin
            // half over the whole grid, half over the small inner features
            if ($urandom_range(0, 1))
            begin
                c = $urandom_range(0, 255);
                r = $urandom_range(0, 255);
            end
            else
            begin
                c = $urandom_range(80, 176);
                r = $urandom_range(40, 180);
            end
            send_pixel(c, r);
        end
    endtask

    task automatic quiesce();
        px_valid <= 1'b0;
        @(negedge clk);
        while (in_flight != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stall;
        dn_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            else if (quiet)
                stall = 0;
            else
                stall = $urandom_range(0, 4);
            if (stall > 0)
            begin
                dn_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            dn_ready <= 1'b1;
            @(posedge clk);
            while (!dn_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        px_valid = 1'b0;
        col      = '0;
        row      = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // grid corners and center
        send_pixel(8'd0, 8'd0);
        send_pixel(8'd255, 8'd255);
        send_pixel(8'd0, 8'd255);
        send_pixel(8'd255, 8'd0);
        send_pixel(8'd128, 8'd128);
        send_pixel(8'd127, 8'd127);
        // skull ring, left and right, top and bottom
        send_pixel(8'd214, 8'd128);
        send_pixel(8'd42, 8'd128);
        send_pixel(8'd128, 8'd241);
        send_pixel(8'd128, 8'd13);
        // tilted dark ellipses
        send_pixel(8'd156, 8'd128);
        send_pixel(8'd100, 8'd128);
        send_pixel(8'd100, 8'd100);
        // upper and the two small central blobs
        send_pixel(8'd128, 8'd173);
        send_pixel(8'd128, 8'd141);
        send_pixel(8'd128, 8'd115);
        // the three tiny ellipses near the bottom
        send_pixel(8'd118, 8'd51);
        send_pixel(8'd128, 8'd51);
        send_pixel(8'd136, 8'd51);
        // near edges of the outer ellipses
        send_pixel(8'd216, 8'd128);
        send_pixel(8'd217, 8'd128);
        send_pixel(8'd128, 8'd246);
        send_pixel(8'd213, 8'd128);
        send_pixel(8'd85, 8'd170);

        run_phase(PHASE_LEN);

        quiet = 1'b1;
        run_phase(PHASE_LEN);
        quiet = 1'b0;

        // receiver stops for a while, pipe fills and px_ready drops
        hold_req = 1'b1;
        run_phase(PHASE_LEN);

        // sender waits for the pipe to drain
        quiesce();
        run_phase(PHASE_LEN);

        quiesce();
        repeat (TAIL_WAIT) @(negedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
